/* rtl/ttmf_pkg.sv */
// ============================================================================
// ttmf_pkg
// shared types and constants of the tank track mixer and framer
// ============================================================================
`default_nettype none

package ttmf_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] FRAME_START0 = 8'h01;
  localparam logic [7:0] FRAME_START1 = 8'hFF;
  localparam logic [7:0] TRACK_CENTER = 8'd127;
  localparam logic [7:0] WEAPON_ON    = 8'd2;
  localparam logic [7:0] WEAPON_OFF   = 8'd0;

  // byte positions within the frame
  localparam logic [IDX_W-1:0] POS_START0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_START1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_RIGHT  = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_LEFT   = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_PAD0   = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_PAD1   = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_CANNON = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_LASER  = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_GUN    = IDX_W'(8);

  typedef struct packed {
    logic              update_controls;
    logic signed [7:0] forward_speed;
    logic signed [7:0] turn_speed;
    logic              cannon_on;
    logic              laser_on;
    logic              gun_on;
    logic              send_frame;
  } ttmf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } ttmf_out_t;

  // snapshot of state taken for one send request
  typedef struct packed {
    logic [7:0] right_track;
    logic [7:0] left_track;
    logic       cannon;
    logic       laser;
    logic       gun;
  } ttmf_frame_t;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

`default_nettype wire

/* rtl/ttmf_front.sv */
// ============================================================================
// ttmf_front
// request intake: track mixing, held state, frame snapshot push
// ============================================================================
`default_nettype none

module ttmf_front
  import ttmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire ttmf_in_t    req,
  output logic             push,
  output ttmf_frame_t      push_data
);

  logic [7:0] left_track_r, left_track_nxt;
  logic [7:0] right_track_r, right_track_nxt;
  logic       cannon_r, cannon_nxt;
  logic       laser_r, laser_nxt;
  logic       gun_r, gun_nxt;

  logic signed [8:0] fwd_ext;
  logic signed [8:0] turn_ext;
  logic signed [8:0] turn_neg;

  // piecewise mix, saturated to -127..127, then offset by 127
  function automatic logic [7:0] mix_track(input logic signed [8:0] x,
                                           input logic signed [8:0] y);
    logic signed [10:0] xs;
    logic signed [10:0] ys;
    logic signed [10:0] ax;
    logic signed [10:0] ay;
    logic signed [10:0] m;
    logic signed [10:0] sum;
    xs = {{2{x[8]}}, x};
    ys = {{2{y[8]}}, y};
    ax = xs[10] ? -xs : xs;
    ay = ys[10] ? -ys : ys;
    if (!ys[10]) begin
      if (xs > 11'sd0) m = ys - xs;
      else             m = (ax > ay) ? ax : ay;
    end else begin
      if (xs > 11'sd0) m = (ax > ay) ? (-xs - ys) : (xs + ys);
      else             m = (ax <= ay) ? ys : (xs - (ys <<< 1));
    end
    if (m > 11'sd127)  m = 11'sd127;
    if (m < -11'sd127) m = -11'sd127;
    sum = m + 11'sd127;
    return sum[7:0];
  endfunction

  assign fwd_ext  = {req.forward_speed[7], req.forward_speed};
  assign turn_ext = {req.turn_speed[7], req.turn_speed};
  assign turn_neg = -turn_ext;

  always_comb begin
    left_track_nxt  = left_track_r;
    right_track_nxt = right_track_r;
    cannon_nxt      = cannon_r;
    laser_nxt       = laser_r;
    gun_nxt         = gun_r;
    if (acc && req.update_controls) begin
      left_track_nxt  = mix_track(turn_neg, fwd_ext);
      right_track_nxt = mix_track(turn_ext, fwd_ext);
      cannon_nxt      = req.cannon_on;
      laser_nxt       = req.laser_on;
      gun_nxt         = req.gun_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_track_r  <= TRACK_CENTER;
      right_track_r <= TRACK_CENTER;
      cannon_r      <= 1'b0;
      laser_r       <= 1'b0;
      gun_r         <= 1'b0;
    end else begin
      left_track_r  <= left_track_nxt;
      right_track_r <= right_track_nxt;
      cannon_r      <= cannon_nxt;
      laser_r       <= laser_nxt;
      gun_r         <= gun_nxt;
    end
  end

  // update comes before send: snapshot the post-update values
  assign push                  = acc && req.send_frame;
  assign push_data.right_track = right_track_nxt;
  assign push_data.left_track  = left_track_nxt;
  assign push_data.cannon      = cannon_nxt;
  assign push_data.laser       = laser_nxt;
  assign push_data.gun         = gun_nxt;

endmodule

`default_nettype wire

/* rtl/ttmf_fifo.sv */
// ============================================================================
// ttmf_fifo
// small queue of frame snapshots between intake and framer
// ============================================================================
`default_nettype none

module ttmf_fifo
  import ttmf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire ttmf_frame_t  push_data,
  input  wire logic         pop,
  output ttmf_frame_t       pop_data,
  output logic              full,
  output logic              empty
);

  ttmf_frame_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]     count_r, count_nxt;

  assign full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/ttmf_back.sv */
// ============================================================================
// ttmf_back
// framer: serializes one snapshot into nine registered output bytes
// ============================================================================
`default_nettype none

module ttmf_back
  import ttmf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire ttmf_frame_t  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ttmf_out_t         out_data
);

  ttmf_frame_t      frame_r, frame_nxt;
  logic             active_r, active_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             ovalid_r, ovalid_nxt;
  ttmf_out_t        odata_r, odata_nxt;

  logic             load;
  logic             is_last;
  logic [7:0]       cur_byte;

  assign load    = active_r && (!ovalid_r || !out_stall);
  assign is_last = (pos_r == POS_GUN);

  always_comb begin
    case (pos_r)
      POS_START0: cur_byte = FRAME_START0;
      POS_START1: cur_byte = FRAME_START1;
      POS_RIGHT:  cur_byte = frame_r.right_track;
      POS_LEFT:   cur_byte = frame_r.left_track;
      POS_PAD0:   cur_byte = TRACK_CENTER;
      POS_PAD1:   cur_byte = TRACK_CENTER;
      POS_CANNON: cur_byte = frame_r.cannon ? WEAPON_ON : WEAPON_OFF;
      POS_LASER:  cur_byte = frame_r.laser  ? WEAPON_ON : WEAPON_OFF;
      POS_GUN:    cur_byte = frame_r.gun    ? WEAPON_ON : WEAPON_OFF;
      default:    cur_byte = WEAPON_OFF;
    endcase
  end

  // next frame is taken when idle or while the last byte goes out
  assign q_pop = !q_empty && (!active_r || (load && is_last));

  always_comb begin
    frame_nxt  = frame_r;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (load) begin
      ovalid_nxt          = 1'b1;
      odata_nxt.out_byte  = cur_byte;
      odata_nxt.last_byte = is_last;
      pos_nxt             = pos_r + 1'b1;
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      frame_nxt  = q_data;
      active_nxt = 1'b1;
      pos_nxt    = POS_START0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= POS_START0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

`default_nettype wire

/* rtl/tank_track_mixer_framer_top.sv */
// ============================================================================
// tank_track_mixer_framer_top
// mixes forward/turn commands into track speeds and frames them on request
// ============================================================================
//
//   channel   ports                          payload     direction
//   input     in_valid / in_stall / in_data  ttmf_in_t   request in
//   output    out_valid / out_stall / out_data ttmf_out_t frame bytes out
//
// - a request is taken when in_valid is high and in_stall is low; the update is
//   applied at once and a send request pushes a snapshot into a two-entry queue
// - the framer drains the queue at one byte per cycle while out_stall is low,
//   so a send request costs nine output bytes; update-only requests cost none
// - in_stall rises only when the snapshot queue is full
// - synchronous active-low reset puts both tracks at 127 and flags off
// - the output byte sits in a register; out_stall holds it in place
//
`default_nettype none

module tank_track_mixer_framer_top
  import ttmf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ttmf_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ttmf_out_t      out_data
);

  logic        acc;
  logic        push;
  ttmf_frame_t push_data;
  logic        pop;
  ttmf_frame_t pop_data;
  logic        q_full;
  logic        q_empty;

  // intake waits only for room in the snapshot queue
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  ttmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (in_data),
    .push      (push),
    .push_data (push_data)
  );

  ttmf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ttmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
